### rtl/assert_macros.svh
// Assertion helpers for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ESU_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Antecedent implies consequent in the following cycle.
`define ESU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

### rtl/esu_pkg.sv
// ---------------------------------------------------------------------------
// esu_pkg
// Types, constants and helper functions of the escape sequence unescaper.
// ---------------------------------------------------------------------------
package esu_pkg;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

   localparam logic [1:0] MODE_COOKED     = 2'd0;
   localparam logic [1:0] MODE_RAW_STRING = 2'd1;
   localparam logic [1:0] MODE_RAW_REGEX  = 2'd2;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_SLASH     = 8'h2f;
   localparam logic [7:0] CHAR_LOWER_N   = 8'h6e;
   localparam logic [7:0] CHAR_LOWER_R   = 8'h72;
   localparam logic [7:0] CHAR_LOWER_T   = 8'h74;
   localparam logic [7:0] CHAR_LOWER_X   = 8'h78;
   localparam logic [7:0] CHAR_LOWER_U   = 8'h75;
   localparam logic [7:0] CHAR_UPPER_U   = 8'h55;
   localparam logic [7:0] CHAR_NEWLINE   = 8'h0a;
   localparam logic [7:0] CHAR_RETURN    = 8'h0d;
   localparam logic [7:0] CHAR_TAB       = 8'h09;

   localparam logic [7:0] UTF8_LEAD_2 = 8'hc0;
   localparam logic [7:0] UTF8_LEAD_3 = 8'he0;
   localparam logic [7:0] UTF8_LEAD_4 = 8'hf0;
   localparam logic [7:0] UTF8_LEAD_5 = 8'hf8;
   localparam logic [7:0] UTF8_LEAD_6 = 8'hfc;
   localparam logic [7:0] UTF8_CONT   = 8'h80;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_BAD_HEX   = 2'd1,
      ERR_TOO_LARGE = 2'd2
   } error_code_type;

   typedef enum logic [1:0] {
      CMD_LITERAL,     // one byte as is
      CMD_ESCAPED,     // backslash, then the byte
      CMD_CODE_POINT,  // UTF-8 encode, or too large
      CMD_BAD_HEX      // error result
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [2:0]   len;    // result bytes, 1 to 6
      logic [31:0]  data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   // {valid, value} of an ASCII hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         r = {1'b1, c[3:0] + 4'd9};
      end else begin
         r = 5'd0;
      end
      return r;
   endfunction

   function automatic logic [2:0] utf8_len(input logic [31:0] cp);
      logic [2:0] r;
      if (cp <= 32'h7f) begin
         r = 3'd1;
      end else if (cp <= 32'h7ff) begin
         r = 3'd2;
      end else if (cp <= 32'hffff) begin
         r = 3'd3;
      end else if (cp <= 32'h1fffff) begin
         r = 3'd4;
      end else if (cp <= 32'h3ffffff) begin
         r = 3'd5;
      end else begin
         r = 3'd6;
      end
      return r;
   endfunction

   // byte idx (0 = lead) of a len-byte encoding of cp
   function automatic logic [7:0] utf8_byte(input logic [31:0] cp, input logic [2:0] len,
                                            input logic [2:0] idx);
      logic [2:0]  sh;
      logic [31:0] chunk;
      logic [7:0]  r;
      sh = len - idx - 3'd1;
      unique case (sh)
         3'd0:    chunk = cp;
         3'd1:    chunk = cp >> 6;
         3'd2:    chunk = cp >> 12;
         3'd3:    chunk = cp >> 18;
         3'd4:    chunk = cp >> 24;
         3'd5:    chunk = cp >> 30;
         default: chunk = cp;
      endcase
      if (len == 3'd1) begin
         r = cp[7:0];
      end else if (idx == 3'd0) begin
         unique case (len)
            3'd2:    r = UTF8_LEAD_2 | {3'b000, chunk[4:0]};
            3'd3:    r = UTF8_LEAD_3 | {4'b0000, chunk[3:0]};
            3'd4:    r = UTF8_LEAD_4 | {5'b00000, chunk[2:0]};
            3'd5:    r = UTF8_LEAD_5 | {6'b000000, chunk[1:0]};
            default: r = UTF8_LEAD_6 | {7'b0000000, chunk[0]};
         endcase
      end else begin
         r = UTF8_CONT | {2'b00, chunk[5:0]};
      end
      return r;
   endfunction

endpackage

### rtl/escape_sequence_unescaper.sv
// ---------------------------------------------------------------------------
// escape_sequence_unescaper
// Unescapes a byte stream and UTF-8 encodes hex escapes.
// ---------------------------------------------------------------------------
// Requests enter on req_* (valid/stall), one string byte each, with
// req_end_of_string on the final byte. Results leave on rsp_*, one byte a
// cycle while rsp_stall is low, rsp_last_of_run set on the last byte that a request caused.
// csr_escape_mode selects cooked, raw string or raw regex handling; write it
// only while the block is idle. csr_ready is always high.
// An accepted request passes through the command queue into the output
// register. Throughput: one request a cycle while each yields at most one
// byte and rsp_stall is low; a request that yields n bytes holds the back end
// until all n have left (up to six for a UTF-8 sequence), and the four-entry
// command queue absorbs the bursts. Requests that only open an escape or carry
// any but the last hex digit yield nothing. When rsp_stall is high the result
// register holds; once the queue fills, req_stall rises. Reset clears the mode
// to cooked, the escape state and the queue; no clearing pass is needed.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module escape_sequence_unescaper
   import esu_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_string,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_error_code,
   output logic       rsp_last_of_run,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [1:0] csr_escape_mode
);

   fifo_status_type fifo_status;
   logic            push;
   logic            pop;
   cmd_type         push_cmd;
   cmd_type         head_cmd;

   esu_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_string (req_end_of_string),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_escape_mode   (csr_escape_mode),
      .fifo_status       (fifo_status),
      .push              (push),
      .push_cmd          (push_cmd)
   );

   esu_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (fifo_status)
   );

   esu_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_cmd        (head_cmd),
      .fifo_status     (fifo_status),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_last_of_run (rsp_last_of_run)
   );

   `ESU_ASSERT_IMPLIES(a_no_push_when_full, clock, reset, push, !fifo_status.full)
   `ESU_ASSERT_IMPLIES(a_no_pop_when_empty, clock, reset, pop, !fifo_status.empty)
   `ESU_ASSERT_NEXT(a_push_fills_empty, clock, reset, push && fifo_status.empty, !fifo_status.empty)
   `ESU_ASSERT_IMPLIES(a_error_is_single, clock, reset, rsp_valid && (rsp_error_code != ERR_NONE), (rsp_out_byte == 8'd0) && rsp_last_of_run)

endmodule

### rtl/esu_front.sv
// ---------------------------------------------------------------------------
// esu_front
// Accepts input bytes, tracks escape state and pushes one command per byte
// that yields output.
// ---------------------------------------------------------------------------
module esu_front
   import esu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic [7:0]      req_data_byte,
   input  logic            req_end_of_string,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [1:0]      csr_escape_mode,
   input  fifo_status_type fifo_status,
   output logic            push,
   output cmd_type         push_cmd
);

   logic [1:0]  mode_ff;
   logic        pending_ff, pending_in;
   logic [3:0]  digits_ff, digits_in;
   logic [31:0] acc_ff, acc_in;
   logic        accept;
   logic [4:0]  hex;
   logic [31:0] acc_shift;
   logic        emit;
   cmd_type     cmd;

   assign req_stall = fifo_status.full;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && !req_stall;
   assign hex       = hex_value(req_data_byte);
   assign acc_shift = {acc_ff[27:0], hex[3:0]};

   always_comb begin
      pending_in = pending_ff;
      digits_in  = digits_ff;
      acc_in     = acc_ff;
      emit       = 1'b0;
      cmd.kind   = CMD_LITERAL;
      cmd.len    = 3'd1;
      cmd.data   = {24'd0, req_data_byte};

      priority if (digits_ff != 4'd0) begin
         if (!hex[4]) begin
            emit      = 1'b1;
            cmd.kind  = CMD_BAD_HEX;
            digits_in = 4'd0;
            acc_in    = 32'd0;
         end else begin
            acc_in    = acc_shift;
            digits_in = digits_ff - 4'd1;
            if (digits_ff == 4'd1) begin
               emit     = 1'b1;
               cmd.kind = CMD_CODE_POINT;
               cmd.data = acc_shift;
               cmd.len  = acc_shift[31] ? 3'd1 : utf8_len(acc_shift);
               acc_in   = 32'd0;
            end
         end
      end else if (pending_ff) begin
         pending_in = 1'b0;
         emit       = 1'b1;
         priority if (mode_ff == MODE_RAW_REGEX) begin
            if (req_data_byte != CHAR_SLASH) begin
               cmd.kind = CMD_ESCAPED;
               cmd.len  = 3'd2;
            end
         end else if (mode_ff == MODE_RAW_STRING) begin
            if (req_data_byte != CHAR_QUOTE) begin
               cmd.kind = CMD_ESCAPED;
               cmd.len  = 3'd2;
            end
         end else begin
            unique case (req_data_byte)
               CHAR_LOWER_N: cmd.data = {24'd0, CHAR_NEWLINE};
               CHAR_LOWER_R: cmd.data = {24'd0, CHAR_RETURN};
               CHAR_LOWER_T: cmd.data = {24'd0, CHAR_TAB};
               CHAR_QUOTE, CHAR_SLASH, CHAR_BACKSLASH: ;
               CHAR_LOWER_X: begin
                  emit      = 1'b0;
                  digits_in = 4'd2;
                  acc_in    = 32'd0;
               end
               CHAR_LOWER_U: begin
                  emit      = 1'b0;
                  digits_in = 4'd4;
                  acc_in    = 32'd0;
               end
               CHAR_UPPER_U: begin
                  emit      = 1'b0;
                  digits_in = 4'd8;
                  acc_in    = 32'd0;
               end
               default: begin
                  cmd.kind = CMD_ESCAPED;
                  cmd.len  = 3'd2;
               end
            endcase
         end
      end else if (req_data_byte == CHAR_BACKSLASH) begin
         pending_in = 1'b1;
         // a lone backslash at the end of the string comes out as itself
         if (req_end_of_string) begin
            emit = 1'b1;
         end
      end else begin
         emit = 1'b1;
      end

      if (req_end_of_string) begin
         pending_in = 1'b0;
         digits_in  = 4'd0;
         acc_in     = 32'd0;
      end
   end

   assign push     = accept && emit;
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_COOKED;
         pending_ff <= 1'b0;
         digits_ff  <= 4'd0;
         acc_ff     <= 32'd0;
      end else begin
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_escape_mode;
         end
         if (accept) begin
            pending_ff <= pending_in;
            digits_ff  <= digits_in;
            acc_ff     <= acc_in;
         end
      end
   end

endmodule

### rtl/esu_fifo.sv
// ---------------------------------------------------------------------------
// esu_fifo
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module esu_fifo
   import esu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  cmd_type         push_cmd,
   input  logic            pop,
   output cmd_type         head_cmd,
   output fifo_status_type status
);

   cmd_type               entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff;
   logic [FIFO_CNT_W-1:0] count_ff;

   assign head_cmd     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign status.empty = (count_ff == '0);

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + FIFO_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + FIFO_PTR_W'(1);
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + FIFO_CNT_W'(1);
            2'b01:   count_ff <= count_ff - FIFO_CNT_W'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

### rtl/esu_back.sv
// ---------------------------------------------------------------------------
// esu_back
// Expands queued commands into result bytes in an output register, one a
// cycle while rsp_stall is low.
// ---------------------------------------------------------------------------
module esu_back
   import esu_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cmd_type         head_cmd,
   input  fifo_status_type fifo_status,
   output logic            pop,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_error_code,
   output logic            rsp_last_of_run
);

   logic [2:0]     idx_ff, idx_in;
   logic           valid_ff, valid_in;
   logic [7:0]     byte_ff, byte_in;
   error_code_type err_ff, err_in;
   logic           last_ff;
   logic           load;
   logic           last_byte;

   assign load      = !fifo_status.empty && (!valid_ff || !rsp_stall);
   assign last_byte = (idx_ff == head_cmd.len - 3'd1);
   assign pop       = load && last_byte;
   assign idx_in    = last_byte ? 3'd0 : idx_ff + 3'd1;
   // hold a stalled result, drop one that was taken
   assign valid_in  = load || (valid_ff && rsp_stall);

   always_comb begin
      byte_in = head_cmd.data[7:0];
      err_in  = ERR_NONE;
      unique case (head_cmd.kind)
         CMD_LITERAL: ;
         CMD_ESCAPED: begin
            if (idx_ff == 3'd0) begin
               byte_in = CHAR_BACKSLASH;
            end
         end
         CMD_CODE_POINT: begin
            if (head_cmd.data[31]) begin
               byte_in = 8'd0;
               err_in  = ERR_TOO_LARGE;
            end else begin
               byte_in = utf8_byte(head_cmd.data, head_cmd.len, idx_ff);
            end
         end
         CMD_BAD_HEX: begin
            byte_in = 8'd0;
            err_in  = ERR_BAD_HEX;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= 3'd0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            idx_ff <= idx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         byte_ff <= byte_in;
         err_ff  <= err_in;
         last_ff <= last_byte;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_error_code  = err_ff;
   assign rsp_last_of_run = last_ff;

endmodule

### verif/escape_sequence_unescaper_tb.sv
// ---------------------------------------------------------------------------
// escape_sequence_unescaper_tb
// Self-checking bench for the escape sequence unescaper. Strings of escaped
// bytes go in, one request each; a behavioural copy of the unescaper predicts
// the output bytes, which are compared field by field as they leave. Covers
// cooked, raw string, raw regex and the unused mode, UTF-8 lengths 1 to 6,
// bad hex and oversize code points, broken string ends and back-pressure.
// ---------------------------------------------------------------------------
module escape_sequence_unescaper_tb;
   import esu_pkg::*;

   localparam int         STALL_PERCENT   = 26;
   localparam int         HOLD_OFF_CYCLES = 60;
   localparam int         SETTLE_CYCLES   = 6;
   localparam int         WATCHDOG_LIMIT  = 2000;
   localparam int         MAX_REPORTS     = 50;
   localparam logic [1:0] MODE_UNUSED     = 2'd3;

   typedef struct packed {
      logic [7:0]     out_byte;
      error_code_type error_code;
      logic           last_of_run;
   } expected_type;

   typedef logic [7:0] byte_list_type[$];

   logic       clock             = 1'b0;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte     = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall         = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_error_code;
   logic       rsp_last_of_run;
   logic       csr_valid         = 1'b0;
   logic       csr_ready;
   logic [1:0] csr_escape_mode   = MODE_COOKED;

   // unescaper state as the block should hold it
   logic [1:0]  mode_copy      = MODE_COOKED;
   logic        backslash_seen = 1'b0;
   logic [3:0]  digits_owed    = 4'd0;
   logic [31:0] cp_gathered    = 32'd0;

   expected_type  unescaped_due[$];
   expected_type  run_bytes[$];
   byte_list_type text;

   logic idling_on        = 1'b1;
   logic hold_off_request = 1'b0;
   int   hold_left        = 0;
   int   quiet_cycles     = 0;
   int   error_count      = 0;
   int   requests_sent    = 0;
   int   bytes_checked    = 0;
   int   error_results    = 0;
   int   input_stalls     = 0;

   escape_sequence_unescaper u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_of_run   (rsp_last_of_run),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_escape_mode   (csr_escape_mode)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Prediction
   // ------------------------------------------------------------------------
   function automatic void add_byte(input logic [7:0] b, input error_code_type e);
      expected_type r;
      r.out_byte    = b;
      r.error_code  = e;
      r.last_of_run = 1'b0;
      run_bytes.push_back(r);
   endfunction

   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic void encode_cp_utf8(input logic [31:0] cp);
      int         tail;
      logic [7:0] lead;
      if (cp > 32'h7fff_ffff) begin
         add_byte(8'h00, ERR_TOO_LARGE);
         return;
      end
      if (cp <= 32'h7f) begin
         add_byte(cp[7:0], ERR_NONE);
         return;
      end
      if (cp <= 32'h7ff) begin
         tail = 1;
         lead = UTF8_LEAD_2;
      end else if (cp <= 32'hffff) begin
         tail = 2;
         lead = UTF8_LEAD_3;
      end else if (cp <= 32'h1f_ffff) begin
         tail = 3;
         lead = UTF8_LEAD_4;
      end else if (cp <= 32'h3ff_ffff) begin
         tail = 4;
         lead = UTF8_LEAD_5;
      end else begin
         tail = 5;
         lead = UTF8_LEAD_6;
      end
      // the bits above the continuation bytes always fit the lead's spare bits
      add_byte(lead | 8'(cp >> (6 * tail)), ERR_NONE);
      for (int k = tail - 1; k >= 0; k--) begin
         add_byte(UTF8_CONT | {2'b00, 6'(cp >> (6 * k))}, ERR_NONE);
      end
   endfunction

   function automatic void unescape_byte(input logic [7:0] c, input logic eos);
      int d;
      run_bytes.delete();
      if (digits_owed != 0) begin
         d = hex_nibble(c);
         if (d < 0) begin
            add_byte(8'h00, ERR_BAD_HEX);
            digits_owed = 4'd0;
            cp_gathered = 32'd0;
         end else begin
            cp_gathered = {cp_gathered[27:0], 4'(d)};
            digits_owed = digits_owed - 4'd1;
            if (digits_owed == 0) begin
               encode_cp_utf8(cp_gathered);
               cp_gathered = 32'd0;
            end
         end
      end else if (backslash_seen) begin
         backslash_seen = 1'b0;
         if (mode_copy == MODE_RAW_STRING || mode_copy == MODE_RAW_REGEX) begin
            if ((mode_copy == MODE_RAW_STRING && c == CHAR_QUOTE) ||
                (mode_copy == MODE_RAW_REGEX && c == CHAR_SLASH)) begin
               add_byte(c, ERR_NONE);
            end else begin
               add_byte(CHAR_BACKSLASH, ERR_NONE);
               add_byte(c, ERR_NONE);
            end
         end else begin
            // cooked, and the unused mode behaves the same
            case (c)
               CHAR_LOWER_N: add_byte(CHAR_NEWLINE, ERR_NONE);
               CHAR_LOWER_R: add_byte(CHAR_RETURN, ERR_NONE);
               CHAR_LOWER_T: add_byte(CHAR_TAB, ERR_NONE);
               CHAR_QUOTE, CHAR_SLASH, CHAR_BACKSLASH: add_byte(c, ERR_NONE);
               CHAR_LOWER_X: begin
                  digits_owed = 4'd2;
                  cp_gathered = 32'd0;
               end
               CHAR_LOWER_U: begin
                  digits_owed = 4'd4;
                  cp_gathered = 32'd0;
               end
               CHAR_UPPER_U: begin
                  digits_owed = 4'd8;
                  cp_gathered = 32'd0;
               end
               default: begin
                  add_byte(CHAR_BACKSLASH, ERR_NONE);
                  add_byte(c, ERR_NONE);
               end
            endcase
         end
      end else if (c == CHAR_BACKSLASH) begin
         backslash_seen = 1'b1;
      end else begin
         add_byte(c, ERR_NONE);
      end

      if (eos) begin
         if (backslash_seen) add_byte(CHAR_BACKSLASH, ERR_NONE);
         backslash_seen = 1'b0;
         digits_owed    = 4'd0;
         cp_gathered    = 32'd0;
      end

      if (run_bytes.size() != 0) run_bytes[run_bytes.size() - 1].last_of_run = 1'b1;
      foreach (run_bytes[i]) unescaped_due.push_back(run_bytes[i]);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------------
   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 10) return "0" + n;
      return 8'(($urandom_range(1) ? "A" : "a") + n - 10);
   endfunction

   function automatic void add_hex_escape(input logic [7:0] letter, input int digits,
                                          input logic [31:0] cp);
      text.push_back(CHAR_BACKSLASH);
      text.push_back(letter);
      for (int k = digits - 1; k >= 0; k--) begin
         text.push_back(hex_char(4'(cp >> (4 * k))));
      end
   endfunction

   function automatic void load_text(input string s);
      text.delete();
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
   endfunction

   function automatic void build_random_string();
      int         pick;
      logic [7:0] b;
      text.delete();
      repeat ($urandom_range(12, 1)) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            do b = 8'($urandom_range(255)); while (b == CHAR_BACKSLASH);
            text.push_back(b);
         end else if (pick < 50) begin
            text.push_back(CHAR_BACKSLASH);
            case ($urandom_range(5))
               0:       text.push_back(CHAR_LOWER_N);
               1:       text.push_back(CHAR_LOWER_R);
               2:       text.push_back(CHAR_LOWER_T);
               3:       text.push_back(CHAR_QUOTE);
               4:       text.push_back(CHAR_SLASH);
               default: text.push_back(CHAR_BACKSLASH);
            endcase
         end else if (pick < 75) begin
            case ($urandom_range(2))
               0:       add_hex_escape(CHAR_LOWER_X, 2, $urandom_range(8'hff));
               1:       add_hex_escape(CHAR_LOWER_U, 4, $urandom_range(16'hffff));
               // random bit length spreads the code point over every UTF-8 size
               default: add_hex_escape(CHAR_UPPER_U, 8, $urandom() >> $urandom_range(32));
            endcase
         end else if (pick < 82) begin
            text.push_back(CHAR_BACKSLASH);
            text.push_back(CHAR_UPPER_U);
            repeat ($urandom_range(7)) text.push_back(hex_char(4'($urandom_range(15))));
            do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0);
            text.push_back(b);
         end else if (pick < 90) begin
            text.push_back(CHAR_BACKSLASH);
            text.push_back(8'($urandom_range(255)));
         end else begin
            text.push_back(8'($urandom_range(255)));
         end
      end
      // break off the string inside an escape now and then
      if ($urandom_range(99) < 15) begin
         text.push_back(CHAR_BACKSLASH);
         if ($urandom_range(1)) begin
            text.push_back(CHAR_LOWER_U);
            repeat ($urandom_range(3)) text.push_back(hex_char(4'($urandom_range(15))));
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_REPORTS) $display("Mismatch at %0t: %s", $time, what);
   endtask

   task automatic send_request(input logic [7:0] b, input logic eos);
      while (idling_on && $urandom_range(99) < STALL_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= b;
      req_end_of_string <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      unescape_byte(b, eos);
      requests_sent++;
   endtask

   task automatic send_text();
      foreach (text[i]) send_request(text[i], i == text.size() - 1);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (unescaped_due.size() != 0) @(posedge clock);
      // hex digits yield nothing, so let the pipeline settle as well
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_escape_mode(input logic [1:0] m);
      wait_for_drain();
      csr_valid       <= 1'b1;
      csr_escape_mode <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      mode_copy = m;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------
   task automatic test_plain_bytes();
      text.delete();
      text.push_back(8'h00);
      text.push_back(8'hff);
      send_text();
   endtask

   task automatic test_named_escapes();
      load_text("\\n\\q");
      send_text();
      load_text("\\");
      send_text();
   endtask

   task automatic test_hex_escapes();
      load_text("\\xAf\\xg\\U80000000\\u1");
      send_text();
   endtask

   task automatic test_raw_modes();
      write_escape_mode(MODE_RAW_STRING);
      load_text("\\\"\\/");
      send_text();
      write_escape_mode(MODE_RAW_REGEX);
      load_text("\\/\\\"");
      send_text();
      write_escape_mode(MODE_UNUSED);
      load_text("\\t");
      send_text();
   endtask

   task automatic test_random_strings(input logic [1:0] m, input int n_requests);
      int stop_at;
      write_escape_mode(m);
      stop_at = requests_sent + n_requests;
      while (requests_sent < stop_at) begin
         build_random_string();
         send_text();
      end
   endtask

   task automatic test_back_pressure();
      int half;
      write_escape_mode(MODE_COOKED);
      idling_on        = 1'b0;
      hold_off_request = 1'b1;
      // six-byte sequences fill the command queue while the receiver holds off
      text.delete();
      repeat (3) begin
         add_hex_escape(CHAR_UPPER_U, 8, 32'h4000_0000 | ($urandom() & 32'h3fff_ffff));
         repeat (4) text.push_back("a" + 8'($urandom_range(25)));
      end
      send_text();
      idling_on = 1'b1;

      // pause mid-string until every result is out, then carry on
      build_random_string();
      half = text.size() / 2;
      foreach (text[i]) begin
         if (i == half) wait_for_drain();
         send_request(text[i], i == text.size() - 1);
      end
   endtask

   task automatic test_full_rate();
      idling_on = 1'b0;
      test_random_strings(MODE_COOKED, 40);
      idling_on = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Receiver, checking and watchdog
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_off_request) begin
         hold_off_request = 1'b0;
         hold_left        = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= idling_on && ($urandom_range(99) < STALL_PERCENT);
      end
   end

   always @(posedge clock) begin : result_check
      expected_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         bytes_checked++;
         if (unescaped_due.size() == 0) begin
            report_mismatch($sformatf("result byte %02h with nothing expected", rsp_out_byte));
         end else begin
            want = unescaped_due.pop_front();
            if (rsp_out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_out_byte, want.out_byte));
            if (rsp_error_code !== want.error_code)
               report_mismatch($sformatf("error_code %0d, expected %0d",
                                         rsp_error_code, want.error_code));
            if (rsp_last_of_run !== want.last_of_run)
               report_mismatch($sformatf("last_of_run %0b, expected %0b",
                                         rsp_last_of_run, want.last_of_run));
            if (want.error_code != ERR_NONE) error_results++;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_stall) input_stalls++;
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: nothing moved for %0d cycles, %0d results outstanding",
                     WATCHDOG_LIMIT, unescaped_due.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_plain_bytes();
      test_named_escapes();
      test_hex_escapes();
      test_raw_modes();
      test_random_strings(MODE_COOKED, 50);
      test_random_strings(MODE_RAW_STRING, 20);
      test_random_strings(MODE_RAW_REGEX, 20);
      test_random_strings(MODE_UNUSED, 12);
      test_back_pressure();
      test_full_rate();
      wait_for_drain();

      $display("Run covered %0d requests over all four escape modes;", requests_sent);
      $display("%0d bytes checked, %0d error results, input held off for %0d cycles",
               bytes_checked, error_results, input_stalls);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/esu_pkg.sv
rtl/esu_front.sv
rtl/esu_fifo.sv
rtl/esu_back.sv
rtl/escape_sequence_unescaper.sv
verif/escape_sequence_unescaper_tb.sv
